[rtl/core/mfbm_pkg.sv]
// Shared types and constants for the multi-frame bit-matrix buffer.
// Holds the command codes, the item field widths and the request/response structs.
// No dependencies.
`timescale 1ns / 1ps

package mfbm_pkg;

    // Fixed field widths of one transaction
    localparam int CMD_W   = 3;
    localparam int FRAME_W = 2;
    localparam int COL_W   = 3;
    localparam int ROW_W   = 3;
    localparam int FIU_W   = 3;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Default geometry
    localparam int COLUMNS_DEF    = 8;
    localparam int ROWS_DEF       = 8;
    localparam int MAX_FRAMES_DEF = 4;

    // Reset value of frames_in_use
    localparam logic [FIU_W-1:0] FIU_RESET = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_SHIFT = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_FILL  = 3'd4,
        CMD_DROP  = 3'd5
    } t_cmd;

    // Request: command sits in the low bits so it lines up with tdata
    typedef struct packed {
        logic             pixel_value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [FRAME_W-1:0] frame_index;
        logic [CMD_W-1:0] command;
    } t_req;

    localparam int REQ_W = $bits(t_req);

    // Response: read_value in bit 0, status in bit 1
    typedef struct packed {
        logic status;
        logic read_value;
    } t_rsp;

    localparam int RSP_W = $bits(t_rsp);

endpackage

[rtl/core/mfbm_core.sv]
// Column-word store and command execution; next contents and response are combinational.
// Holds one ROWS-bit word per frame and column; depends on mfbm_pkg.
`timescale 1ns / 1ps

module mfbm_core #(
    parameter int COLUMNS    = mfbm_pkg::COLUMNS_DEF,
    parameter int ROWS       = mfbm_pkg::ROWS_DEF,
    parameter int MAX_FRAMES = mfbm_pkg::MAX_FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  mfbm_pkg::t_req              i_req,
    input  logic [mfbm_pkg::FIU_W-1:0]  i_frames_in_use,
    output mfbm_pkg::t_rsp              o_rsp
);
    import mfbm_pkg::*;

    localparam int NF_BITS = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W   = (NF_BITS > FIU_W) ? NF_BITS : FIU_W;
    localparam int FIW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CIW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RIW     = $clog2(ROWS);

    logic [ROWS-1:0] r_bits [MAX_FRAMES][COLUMNS];
    logic [ROWS-1:0] n_bits [MAX_FRAMES][COLUMNS];

    logic [CMP_W-1:0] fiu_ext;
    logic [CMP_W-1:0] nf;
    logic             frame_ok;
    logic             col_ok;
    logic             row_ok;
    logic [FIW-1:0]   frame_idx;
    logic [CIW-1:0]   col_idx;
    logic [RIW-1:0]   row_idx;
    logic [ROWS-1:0]  cur_word;
    logic [ROWS-1:0]  fill_mask;
    logic             rd;
    logic             st;

    // Clear the highest set bit among rows ROWS-1 down to 1
    function automatic logic [ROWS-1:0] drop_top(input logic [ROWS-1:0] w);
        logic [ROWS-1:0] res;
        res = w;
        for (int i = 1; i < ROWS; i++) begin
            if (w[i] && ((w >> (i + 1)) == '0)) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    // Frames in use, saturated to 1..MAX_FRAMES
    always_comb begin
        fiu_ext = CMP_W'(i_frames_in_use);
        if (fiu_ext == '0) begin
            nf = CMP_W'(1);
        end else if (fiu_ext > CMP_W'(MAX_FRAMES)) begin
            nf = CMP_W'(MAX_FRAMES);
        end else begin
            nf = fiu_ext;
        end
    end

    // Address decode and range checks
    assign frame_ok  = CMP_W'(i_req.frame_index) < nf;
    assign col_ok    = 32'(i_req.column) < 32'(COLUMNS);
    assign row_ok    = 32'(i_req.row) < 32'(ROWS);
    assign frame_idx = FIW'(i_req.frame_index);
    assign col_idx   = CIW'(i_req.column);
    assign row_idx   = RIW'(i_req.row);
    assign cur_word  = r_bits[frame_idx][col_idx];

    // Rows 0 up to the requested row; rows past the top saturate naturally
    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            fill_mask[i] = 32'(i_req.row) >= 32'(i);
        end
    end

    // Next store contents and response
    always_comb begin
        n_bits = r_bits;
        rd     = 1'b0;
        st     = 1'b0;
        case (t_cmd'(i_req.command))
            CMD_SHIFT: begin
                for (int f = 0; f < MAX_FRAMES; f++) begin
                    if (CMP_W'(f) < nf) begin
                        if (f == 0) begin
                            n_bits[f] = '{default: '0};
                        end else begin
                            n_bits[f] = r_bits[(f == 0) ? 0 : f - 1];
                        end
                    end
                end
            end
            CMD_DROP: begin
                for (int f = 0; f < MAX_FRAMES; f++) begin
                    for (int c = 0; c < COLUMNS; c++) begin
                        if (CMP_W'(f) < nf) begin
                            n_bits[f][c] = drop_top(r_bits[f][c]);
                        end
                    end
                end
            end
            CMD_WRITE, CMD_READ, CMD_CLEAR, CMD_FILL: begin
                if (!frame_ok) begin
                    st = 1'b1;
                end else if (col_ok) begin
                    case (t_cmd'(i_req.command))
                        CMD_WRITE: begin
                            if (row_ok) begin
                                n_bits[frame_idx][col_idx][row_idx] = i_req.pixel_value;
                            end
                        end
                        CMD_READ: begin
                            if (row_ok) begin
                                rd = cur_word[row_idx];
                            end
                        end
                        CMD_CLEAR: begin
                            n_bits[frame_idx][col_idx] = '0;
                        end
                        CMD_FILL: begin
                            n_bits[frame_idx][col_idx] = cur_word | fill_mask;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // Store update; the whole matrix clears at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '{default: '0};
        end else if (i_en) begin
            r_bits <= n_bits;
        end
    end

    assign o_rsp.read_value = rd;
    assign o_rsp.status     = st;

endmodule

[rtl/core/multi_frame_bit_matrix_buffer_unit.sv]
// Top level of the multi-frame bit-matrix buffer: stream handshakes,
// input and result registers and the frames_in_use register. Uses mfbm_pkg and mfbm_core.
`timescale 1ns / 1ps

// Multi-frame bit-matrix buffer for an LED display. Every command (write,
// read, shift frames, clear column, fill column, drop top) executes in
// mfbm_core between the input register and the result register, so the block
// sustains one transaction per clock while the result stream is not stalled.
// Results are presented from the result register; a stalled result holds the
// input register, which in turn holds off the next command. Each command gives
// exactly one result. The store is a register array, cleared at reset and
// updated once per command, so a command always sees the effect of the one
// before it. The user must write frames_in_use through the cfg channel only
// while the block is idle; the block does not enforce this. 0 acts as 1 and
// values above MAX_FRAMES act as MAX_FRAMES.
module multi_frame_bit_matrix_buffer_unit #(
    parameter int COLUMNS    = mfbm_pkg::COLUMNS_DEF,
    parameter int ROWS       = mfbm_pkg::ROWS_DEF,
    parameter int MAX_FRAMES = mfbm_pkg::MAX_FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [2:0] command, [4:3] frame_index, [7:5] column, [10:8] row,
    // [11] pixel_value, [15:12] zero
    input  logic [mfbm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // Result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] read_value, [1] status, [7:2] zero
    output logic [mfbm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // frames_in_use write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mfbm_pkg::FIU_W-1:0]      i_cfg_data
);
    import mfbm_pkg::*;

    logic             r_in_vld;
    t_req             r_req;
    logic             r_out_vld;
    t_rsp             r_rsp;
    logic [FIU_W-1:0] r_fiu;

    logic             out_free;
    logic             exec_en;
    t_rsp             core_rsp;

    // Pipeline advance
    assign out_free   = !r_out_vld || i_m_tready;
    assign exec_en    = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_req <= t_req'(i_s_tdata[REQ_W-1:0]);
        end
    end

    // Command execution and store
    mfbm_core #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (exec_en),
        .i_req           (r_req),
        .i_frames_in_use (r_fiu),
        .o_rsp           (core_rsp)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_TDATA_W'(r_rsp);

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu <= FIU_RESET;
        end else if (i_cfg_valid) begin
            r_fiu <= i_cfg_data;
        end
    end

endmodule
